/* sv/nst_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package nst_pkg;

	localparam int unsigned NAME_BYTES_MAX = 15;
	localparam int unsigned NAME_W         = 8 * NAME_BYTES_MAX;
	localparam int unsigned LOW_W          = 64;
	localparam int unsigned HIGH_W         = 56;
	localparam int unsigned HELD_W         = 8;

	typedef enum logic [1:0] {
		ACT_INSTALL  = 2'd0,
		ACT_REMOVE   = 2'd1,
		ACT_CHECK    = 2'd2,
		ACT_RESERVED = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_DONE        = 3'd0,
		ST_PRESENT     = 3'd1,
		ST_FULL        = 3'd2,
		ST_ABSENT      = 3'd3,
		ST_UNSUPPORTED = 3'd4
	} status_t;

	typedef struct packed {
		action_t             action;
		logic [NAME_W-1:0]   name;
	} req_t;

	typedef struct packed {
		logic    success;
		status_t status;
	} res_t;

	// Clears every byte from the first zero byte on, and every byte at or above
	// the configured name length, so that equal strings give equal words.
	function automatic logic [NAME_W-1:0] norm_name(
		input logic [NAME_W-1:0] raw,
		input int unsigned       nbytes
	);
		logic [NAME_W-1:0] w;
		logic              ended;
		logic [7:0]        b;
		w     = '0;
		ended = 1'b0;
		for (int unsigned i = 0; i < NAME_BYTES_MAX; i++) begin
			b = raw[8*i +: 8];
			if (b == 8'd0 || i >= nbytes) begin
				ended = 1'b1;
			end
			w[8*i +: 8] = ended ? 8'd0 : b;
		end
		return w;
	endfunction

endpackage

`default_nettype wire

/* sv/nst_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module nst_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 2,
	localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

/* sv/nst_seq.sv */
`timescale 1ns / 1ps
`default_nettype none

module nst_seq
	import nst_pkg::*;
#(
	parameter int unsigned ENTRIES = 128,
	localparam int unsigned CW     = $clog2(ENTRIES + 1),
	localparam int unsigned AW     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_ready,
	input  wire req_t          req,
	output logic               res_valid,
	input  wire logic          res_take,
	output res_t               res,
	output logic [CW-1:0]      count
);

	typedef enum logic [5:0] {
		S_IDLE    = 6'b000001,
		S_READ    = 6'b000010,
		S_COMPARE = 6'b000100,
		S_MOVE_RD = 6'b001000,
		S_MOVE_WR = 6'b010000,
		S_FINISH  = 6'b100000
	} state_t;

	state_t            state_q;
	action_t           act_q;
	logic [NAME_W-1:0] name_q;
	logic [CW-1:0]     idx_q;
	logic [CW-1:0]     count_q;
	res_t              res_q;

	logic [CW-1:0]     nxt;
	logic              at_end;
	logic              full;

	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [NAME_W-1:0] ram_wdata;
	logic              ram_re;
	logic [AW-1:0]     ram_raddr;
	logic [NAME_W-1:0] ram_rdata;

	assign nxt    = idx_q + CW'(1);
	assign at_end = (idx_q == count_q);
	assign full   = (count_q == CW'(ENTRIES));

	nst_ram #(
		.WIDTH(NAME_W),
		.DEPTH(ENTRIES)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = count_q[AW-1:0];
		ram_wdata = name_q;
		ram_re    = 1'b0;
		ram_raddr = idx_q[AW-1:0];
		unique case (state_q)
			S_READ: begin
				if (at_end) begin
					ram_we = (act_q == ACT_INSTALL) && !full;
				end else begin
					ram_re = 1'b1;
				end
			end
			S_MOVE_RD: begin
				if (nxt != count_q) begin
					ram_re    = 1'b1;
					ram_raddr = nxt[AW-1:0];
				end
			end
			S_MOVE_WR: begin
				ram_we    = 1'b1;
				ram_waddr = idx_q[AW-1:0];
				ram_wdata = ram_rdata;
			end
			S_IDLE, S_COMPARE, S_FINISH: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						state_q <= (req.action == ACT_RESERVED) ? S_FINISH : S_READ;
					end
				end
				S_READ: begin
					if (at_end) begin
						if (act_q == ACT_INSTALL && !full) begin
							count_q <= count_q + CW'(1);
						end
						state_q <= S_FINISH;
					end else begin
						state_q <= S_COMPARE;
					end
				end
				S_COMPARE: begin
					if (ram_rdata == name_q) begin
						state_q <= (act_q == ACT_REMOVE) ? S_MOVE_RD : S_FINISH;
					end else begin
						state_q <= S_READ;
					end
				end
				S_MOVE_RD: begin
					if (nxt == count_q) begin
						count_q <= count_q - CW'(1);
						state_q <= S_FINISH;
					end else begin
						state_q <= S_MOVE_WR;
					end
				end
				S_MOVE_WR: begin
					state_q <= S_MOVE_RD;
				end
				S_FINISH: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Payload side: request capture, scan index and the pending result.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					act_q         <= req.action;
					name_q        <= req.name;
					idx_q         <= '0;
					res_q.success <= 1'b0;
					res_q.status  <= ST_UNSUPPORTED;
				end
			end
			S_READ: begin
				if (at_end) begin
					if (act_q == ACT_INSTALL) begin
						res_q.success <= !full;
						res_q.status  <= full ? ST_FULL : ST_DONE;
					end else begin
						res_q.success <= 1'b0;
						res_q.status  <= ST_ABSENT;
					end
				end
			end
			S_COMPARE: begin
				if (ram_rdata == name_q) begin
					res_q.success <= 1'b1;
					res_q.status  <= (act_q == ACT_INSTALL) ? ST_PRESENT : ST_DONE;
				end else begin
					idx_q <= nxt;
				end
			end
			S_MOVE_WR: begin
				idx_q <= nxt;
			end
			S_MOVE_RD, S_FINISH: begin
			end
			default: begin
			end
		endcase
	end

	assign req_ready = (state_q == S_IDLE);
	assign res_valid = (state_q == S_FINISH);
	assign res       = res_q;
	assign count     = count_q;

endmodule

`default_nettype wire

/* sv/name_set_table.sv */
// A check or install scans the stored names in order, reading and then comparing
// each entry, until a match or the end of the list; a remove that matches then
// moves each later entry down one place, by a read and a write. One request is
// worked at a time; the next can be taken in the cycle after the result is parked.
// The store's registered read sets the pace of the scan. Reset clears the entry
// count and all control; the name store is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module name_set_table
	import nst_pkg::*;
#(
	parameter int unsigned ENTRIES    = 128,
	parameter int unsigned NAME_BYTES = 15
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [1:0]        action,
	input  wire logic [LOW_W-1:0]  name_low,
	input  wire logic [HIGH_W-1:0] name_high,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic                   success,
	output logic [2:0]             status,
	output logic [HELD_W-1:0]      entries_held
);

	localparam int unsigned CW = $clog2(ENTRIES + 1);

	req_t              req;
	logic              res_valid;
	logic              res_take;
	res_t              res;
	logic [CW-1:0]     count;

	logic              out_valid_q;
	logic              success_q;
	status_t           status_q;
	logic [HELD_W-1:0] held_q;

	assign req.action = action_t'(action);
	assign req.name   = norm_name({name_high, name_low}, NAME_BYTES);

	nst_seq #(
		.ENTRIES(ENTRIES)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (in_valid),
		.req_ready (in_ready),
		.req       (req),
		.res_valid (res_valid),
		.res_take  (res_take),
		.res       (res),
		.count     (count)
	);

	// The output register frees the sequencer as soon as a result is parked.
	assign res_take = res_valid && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			success_q <= res.success;
			status_q  <= res.status;
			held_q    <= HELD_W'(count);
		end
	end

	assign out_valid    = out_valid_q;
	assign success      = success_q;
	assign status       = status_q;
	assign entries_held = held_q;

endmodule

`default_nettype wire

/* dv/name_set_table_checker.sv */
`timescale 1ns / 1ps

module name_set_table_checker
	import nst_pkg::*;
#(
	parameter int unsigned ENTRIES    = 128,
	parameter int unsigned NAME_BYTES = 15
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_ready,
	input  logic [1:0]        action,
	input  logic [LOW_W-1:0]  name_low,
	input  logic [HIGH_W-1:0] name_high,
	input  logic              out_valid,
	input  logic              out_ready,
	input  logic              success,
	input  logic [2:0]        status,
	input  logic [HELD_W-1:0] entries_held,
	output int unsigned       fail_count,
	output int unsigned       outstanding
);

	typedef struct packed {
		logic              ok;
		status_t           st;
		logic [HELD_W-1:0] held;
	} outcome_t;

	logic [NAME_W-1:0] table_names [ENTRIES];
	int unsigned       name_count = 0;
	outcome_t          outcome_q [$];
	int unsigned       result_idx = 0;
	int unsigned       mismatches = 0;
	int unsigned       depth_seen = 0;

	assign fail_count  = mismatches;
	assign outstanding = depth_seen;

	// A name ends at its first zero byte or at the configured length.
	function automatic logic [NAME_W-1:0] canon_name(input logic [NAME_W-1:0] raw);
		logic [NAME_W-1:0] keep;
		bit                live;
		keep = '0;
		live = 1'b1;
		for (int unsigned i = 0; i < NAME_BYTES_MAX; i++) begin
			if (i >= NAME_BYTES || raw[8*i +: 8] == 8'h00) begin
				live = 1'b0;
			end
			if (live) begin
				keep[8*i +: 8] = 8'hFF;
			end
		end
		return raw & keep;
	endfunction

	task automatic predict_outcome(input action_t act, input logic [NAME_W-1:0] raw);
		logic [NAME_W-1:0] key;
		int                hit;
		outcome_t          o;
		key  = canon_name(raw);
		hit  = -1;
		o.ok = 1'b0;
		o.st = ST_UNSUPPORTED;
		for (int i = 0; i < int'(name_count); i++) begin
			if (hit < 0 && table_names[i] == key) begin
				hit = i;
			end
		end
		case (act)
			ACT_INSTALL: begin
				if (hit >= 0) begin
					o.ok = 1'b1;
					o.st = ST_PRESENT;
				end else if (name_count >= ENTRIES) begin
					o.st = ST_FULL;
				end else begin
					table_names[name_count] = key;
					name_count++;
					o.ok = 1'b1;
					o.st = ST_DONE;
				end
			end
			ACT_REMOVE: begin
				if (hit < 0) begin
					o.st = ST_ABSENT;
				end else begin
					// Later entries close the gap so the order is kept.
					for (int j = hit; j + 1 < int'(name_count); j++) begin
						table_names[j] = table_names[j+1];
					end
					name_count--;
					o.ok = 1'b1;
					o.st = ST_DONE;
				end
			end
			ACT_CHECK: begin
				o.ok = (hit >= 0);
				o.st = (hit >= 0) ? ST_DONE : ST_ABSENT;
			end
			default: begin
			end
		endcase
		o.held = name_count[HELD_W-1:0];
		outcome_q.push_back(o);
	endtask

	always @(posedge clk) begin
		outcome_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (outcome_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("result %0d arrived with nothing expected: success=%0b status=%0d held=%0d",
							result_idx, success, status, entries_held);
					end
				end else begin
					want = outcome_q.pop_front();
					if (success !== want.ok || status !== want.st || entries_held !== want.held) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("result %0d differs: expected success=%0b status=%0d held=%0d, got success=%0b status=%0d held=%0d",
								result_idx, want.ok, want.st, want.held,
								success, status, entries_held);
						end
					end
				end
				result_idx++;
			end
			if (in_valid && in_ready) begin
				predict_outcome(action_t'(action), {name_high, name_low});
			end
			depth_seen <= outcome_q.size();
		end
	end

endmodule

/* dv/tb_name_set_table.sv */
`timescale 1ns / 1ps

module tb_name_set_table;
	import nst_pkg::*;

	localparam int unsigned TABLE_DEPTH  = 128;
	localparam int unsigned NAME_LEN     = 15;
	localparam int unsigned RANDOM_REQS  = 1500;
	localparam int unsigned FILL_NAMES   = 140;
	localparam int unsigned POOL_SIZE    = 48;
	localparam int unsigned JUNK_COUNT   = 12;
	localparam int unsigned DRAIN_CYCLES = 600;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic [1:0]        action;
	logic [LOW_W-1:0]  name_low;
	logic [HIGH_W-1:0] name_high;
	logic              out_valid;
	logic              out_ready;
	logic              success;
	logic [2:0]        status;
	logic [HELD_W-1:0] entries_held;
	int unsigned       fail_count;
	int unsigned       outstanding;

	int unsigned       sent = 0;
	bit                steady_tx = 1'b0;
	logic [NAME_W-1:0] pool [POOL_SIZE];
	logic [NAME_W-1:0] fill_set [FILL_NAMES];

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	name_set_table #(
		.ENTRIES   (TABLE_DEPTH),
		.NAME_BYTES(NAME_LEN)
	) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.action      (action),
		.name_low    (name_low),
		.name_high   (name_high),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.success     (success),
		.status      (status),
		.entries_held(entries_held)
	);

	name_set_table_checker #(
		.ENTRIES   (TABLE_DEPTH),
		.NAME_BYTES(NAME_LEN)
	) u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.action      (action),
		.name_low    (name_low),
		.name_high   (name_high),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.success     (success),
		.status      (status),
		.entries_held(entries_held),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [NAME_W-1:0] random_raw();
		logic [127:0] wide;
		wide = {$urandom(), $urandom(), $urandom(), $urandom()};
		return wide[NAME_W-1:0];
	endfunction

	// A clean name of the given length with no zero byte inside it.
	function automatic logic [NAME_W-1:0] spell(input int unsigned len);
		logic [NAME_W-1:0] w;
		w = '0;
		for (int unsigned i = 0; i < len; i++) begin
			w[8*i +: 8] = 8'($urandom_range(1, 255));
		end
		return w;
	endfunction

	// Half the time, fills the bytes after the terminator with junk that the
	// block has to ignore.
	function automatic logic [NAME_W-1:0] disguise(input logic [NAME_W-1:0] w);
		logic [NAME_W-1:0] r;
		bit                ended;
		r     = w;
		ended = 1'b0;
		if ($urandom_range(0, 1) == 0) return w;
		for (int unsigned i = 0; i < NAME_BYTES_MAX; i++) begin
			if (ended) begin
				r[8*i +: 8] = 8'($urandom);
			end
			if (w[8*i +: 8] == 8'h00) begin
				ended = 1'b1;
			end
		end
		return r;
	endfunction

	task automatic issue(input action_t act, input logic [NAME_W-1:0] raw);
		int unsigned gap;
		in_valid  <= 1'b1;
		action    <= act;
		name_low  <= raw[LOW_W-1:0];
		name_high <= raw[NAME_W-1:LOW_W];
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sent++;
		gap = steady_tx ? 0 : pick_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	task automatic mixed_burst(input int unsigned count);
		int unsigned       r;
		logic [NAME_W-1:0] pick;
		for (int unsigned k = 0; k < count; k++) begin
			r    = $urandom_range(0, 99);
			pick = disguise(pool[$urandom_range(0, POOL_SIZE-1)]);
			if (r < 40) issue(ACT_INSTALL, pick);
			else if (r < 70) issue(ACT_REMOVE, pick);
			else if (r < 95) issue(ACT_CHECK, pick);
			else issue(ACT_RESERVED, pick);
		end
	endtask

	// More installs than the table holds, so the last ones hit a full table,
	// then every fill name is removed again in shuffled order.
	task automatic fill_and_drain();
		int unsigned       j;
		logic [NAME_W-1:0] tmp;
		for (int unsigned k = 0; k < FILL_NAMES; k++) begin
			fill_set[k] = spell($urandom_range(3, NAME_LEN));
			issue(ACT_INSTALL, disguise(fill_set[k]));
		end
		for (int unsigned k = 0; k < 8; k++) begin
			issue(ACT_CHECK, disguise(fill_set[$urandom_range(0, FILL_NAMES-1)]));
			issue(ACT_INSTALL, disguise(pool[$urandom_range(0, POOL_SIZE-1)]));
		end
		for (int k = FILL_NAMES - 1; k > 0; k--) begin
			j           = $urandom_range(0, k);
			tmp         = fill_set[k];
			fill_set[k] = fill_set[j];
			fill_set[j] = tmp;
		end
		for (int unsigned k = 0; k < FILL_NAMES; k++) begin
			issue(ACT_REMOVE, disguise(fill_set[k]));
		end
	endtask

	// Raw random requests; whatever they install is taken out again.
	task automatic noise_burst();
		logic [NAME_W-1:0] junk [JUNK_COUNT];
		for (int unsigned k = 0; k < JUNK_COUNT; k++) begin
			junk[k] = random_raw();
			issue(action_t'($urandom_range(0, 3)), junk[k]);
		end
		for (int unsigned k = 0; k < JUNK_COUNT; k++) begin
			issue(ACT_REMOVE, junk[JUNK_COUNT-1-k]);
		end
	endtask

	initial begin : result_sink
		int unsigned taken;
		int unsigned hold_left;
		int unsigned mode_left;
		bit          eager;
		out_ready <= 1'b0;
		taken     = 0;
		hold_left = 0;
		mode_left = 0;
		eager     = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				taken++;
				// Long hold-offs let the block back up into its request side.
				if (taken == 300 || taken == 1000) begin
					hold_left = 400;
				end
			end
			if (mode_left == 0) begin
				mode_left = 200;
				eager     = ($urandom_range(0, 3) == 0);
			end
			mode_left--;
			if (hold_left != 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else if (eager) begin
				out_ready <= 1'b1;
			end else begin
				hold_left = pick_gap();
				out_ready <= (hold_left == 0);
			end
		end
	end

	initial begin : stimulus
		logic [NAME_W-1:0] name_ab;
		logic [NAME_W-1:0] name_one;
		int unsigned       base;
		int unsigned       kind;
		int unsigned       fills;
		int unsigned       episode;
		int unsigned       wait_cycles;
		name_ab   = NAME_W'(16'h6261);
		name_one  = NAME_W'(8'h01);
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		action    <= ACT_INSTALL;
		name_low  <= '0;
		name_high <= '0;
		fills     = 0;
		episode   = 0;
		for (int unsigned k = 0; k < POOL_SIZE; k++) begin
			pool[k] = spell($urandom_range(0, NAME_LEN));
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		issue(ACT_CHECK, '0);
		issue(ACT_REMOVE, NAME_W'(24'h636261));
		issue(ACT_RESERVED, '0);
		issue(ACT_RESERVED, '1);
		issue(ACT_INSTALL, '0);
		// An empty name with junk behind its terminator is still the empty name.
		issue(ACT_INSTALL, {{14{8'hFF}}, 8'h00});
		issue(ACT_INSTALL, '1);
		issue(ACT_CHECK, '1);
		issue(ACT_INSTALL, {{12{8'hEE}}, 8'h00, 16'h6261});
		issue(ACT_CHECK, {{12{8'h5A}}, 8'h00, 16'h6261});
		issue(ACT_CHECK, NAME_W'(24'h636261));
		issue(ACT_INSTALL, name_one);
		issue(ACT_INSTALL, {15{8'hA5}});
		issue(ACT_REMOVE, name_ab);
		issue(ACT_CHECK, '1);
		issue(ACT_CHECK, name_one);
		issue(ACT_REMOVE, '0);
		issue(ACT_REMOVE, '0);
		issue(ACT_CHECK, {{14{8'h33}}, 8'h00});
		issue(ACT_INSTALL, name_ab);
		issue(ACT_REMOVE, '1);
		issue(ACT_RESERVED, name_ab);
		issue(ACT_CHECK, name_ab);
		settle();

		base = sent;
		while (sent - base < RANDOM_REQS) begin
			steady_tx = ($urandom_range(0, 3) == 0);
			kind      = $urandom_range(0, 9);
			if (episode == 1 || (kind == 0 && fills < 2)) begin
				fill_and_drain();
				fills++;
			end else if (kind < 3) begin
				noise_burst();
			end else begin
				mixed_burst($urandom_range(20, 60));
			end
			if ($urandom_range(0, 7) == 0) begin
				settle();
			end
			episode++;
		end
		steady_tx = 1'b0;
		in_valid <= 1'b0;

		@(posedge clk);
		for (wait_cycles = 0; outstanding != 0 && wait_cycles < 400000; wait_cycles++) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && outstanding == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	initial begin : watchdog
		#(200_000_000);
		$display("Mismatches found");
		$finish;
	end

endmodule

/* sim.f */
sv/nst_pkg.sv
sv/nst_ram.sv
sv/nst_seq.sv
sv/name_set_table.sv
dv/name_set_table_checker.sv
dv/tb_name_set_table.sv
